// ----- src/point_segment_distance_top_assert.svh -----
// ---------------------------------------------------------------------------
// point_segment_distance_top_assert.svh
// Assertion macros shared by the checker.
// ---------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_TOP_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_TOP_ASSERT_SVH

// same-cycle implication
`define PSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/psd_pkg.sv -----
// ---------------------------------------------------------------------------
// psd_pkg
// Shared constants, register indexes and types of the point/segment block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int DIST_W          = 36;
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd6;

    localparam logic [1:0] REGION_BEFORE = 2'd0;
    localparam logic [1:0] REGION_PAST   = 2'd1;
    localparam logic [1:0] REGION_ON     = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [1:0] region;
    } psd_ctl_t;

endpackage

`default_nettype wire

// ----- src/psd_front.sv -----
// ---------------------------------------------------------------------------
// psd_front
// Four-stage front end: differences, products, sums, region select.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psd_front #(
    parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [COORD_WIDTH-1:0]     start_x,
    input  wire logic [COORD_WIDTH-1:0]     start_y,
    input  wire logic [COORD_WIDTH-1:0]     start_z,
    input  wire logic [COORD_WIDTH-1:0]     end_x,
    input  wire logic [COORD_WIDTH-1:0]     end_y,
    input  wire logic [COORD_WIDTH-1:0]     end_z,
    input  wire logic [COORD_WIDTH-1:0]     point_x,
    input  wire logic [COORD_WIDTH-1:0]     point_y,
    input  wire logic [COORD_WIDTH-1:0]     point_z,
    output psd_pkg::psd_ctl_t               ctl,
    output logic [2*COORD_WIDTH+1:0]        dot,
    output logic [2*COORD_WIDTH+1:0]        lab,
    output logic [2*COORD_WIDTH+1:0]        base
);

    localparam int D_W = COORD_WIDTH + 1;
    localparam int P_W = 2 * D_W;
    localparam int S_W = P_W + 2;
    localparam int U_W = 2 * COORD_WIDTH + 2;

    logic signed [D_W-1:0] s_ext [3];
    logic signed [D_W-1:0] e_ext [3];
    logic signed [D_W-1:0] p_ext [3];

    // stage 1
    logic                  v1_reg;
    logic signed [D_W-1:0] ab_reg [3];
    logic signed [D_W-1:0] ac_reg [3];
    logic signed [D_W-1:0] bc_reg [3];
    // stage 2
    logic                  v2_reg;
    logic signed [P_W-1:0] pdot_reg [3];
    logic signed [P_W-1:0] pab_reg [3];
    logic signed [P_W-1:0] pac_reg [3];
    logic signed [P_W-1:0] pbc_reg [3];
    // stage 3
    logic                  v3_reg;
    logic signed [S_W-1:0] dot_reg;
    logic signed [S_W-1:0] lab_reg;
    logic signed [S_W-1:0] lac_reg;
    logic signed [S_W-1:0] lbc_reg;
    // stage 4
    psd_pkg::psd_ctl_t     ctl_reg;
    psd_pkg::psd_ctl_t     ctl_next;
    logic [U_W-1:0]        dot4_reg;
    logic [U_W-1:0]        lab4_reg;
    logic [U_W-1:0]        base4_reg;
    logic [U_W-1:0]        base_next;

    always_comb
    begin
        s_ext[0] = {start_x[COORD_WIDTH-1], start_x};
        s_ext[1] = {start_y[COORD_WIDTH-1], start_y};
        s_ext[2] = {start_z[COORD_WIDTH-1], start_z};
        e_ext[0] = {end_x[COORD_WIDTH-1], end_x};
        e_ext[1] = {end_y[COORD_WIDTH-1], end_y};
        e_ext[2] = {end_z[COORD_WIDTH-1], end_z};
        p_ext[0] = {point_x[COORD_WIDTH-1], point_x};
        p_ext[1] = {point_y[COORD_WIDTH-1], point_y};
        p_ext[2] = {point_z[COORD_WIDTH-1], point_z};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ab_reg[k]   <= e_ext[k] - s_ext[k];
                ac_reg[k]   <= p_ext[k] - s_ext[k];
                bc_reg[k]   <= p_ext[k] - e_ext[k];
                pdot_reg[k] <= P_W'(ab_reg[k]) * P_W'(ac_reg[k]);
                pab_reg[k]  <= P_W'(ab_reg[k]) * P_W'(ab_reg[k]);
                pac_reg[k]  <= P_W'(ac_reg[k]) * P_W'(ac_reg[k]);
                pbc_reg[k]  <= P_W'(bc_reg[k]) * P_W'(bc_reg[k]);
            end
            dot_reg <= S_W'(pdot_reg[0]) + S_W'(pdot_reg[1]) + S_W'(pdot_reg[2]);
            lab_reg <= S_W'(pab_reg[0]) + S_W'(pab_reg[1]) + S_W'(pab_reg[2]);
            lac_reg <= S_W'(pac_reg[0]) + S_W'(pac_reg[1]) + S_W'(pac_reg[2]);
            lbc_reg <= S_W'(pbc_reg[0]) + S_W'(pbc_reg[1]) + S_W'(pbc_reg[2]);
        end
    end

    // zero-length segment falls into the before-start case
    always_comb
    begin
        ctl_next.valid = v3_reg;
        if (dot_reg[S_W-1] || (lab_reg == '0))
        begin
            ctl_next.region = psd_pkg::REGION_BEFORE;
            base_next       = lac_reg[U_W-1:0];
        end
        else if (dot_reg > lab_reg)
        begin
            ctl_next.region = psd_pkg::REGION_PAST;
            base_next       = lbc_reg[U_W-1:0];
        end
        else
        begin
            ctl_next.region = psd_pkg::REGION_ON;
            base_next       = lac_reg[U_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot4_reg  <= dot_reg[U_W-1:0];
            lab4_reg  <= lab_reg[U_W-1:0];
            base4_reg <= base_next;
        end
    end

    assign ctl  = ctl_reg;
    assign dot  = dot4_reg;
    assign lab  = lab4_reg;
    assign base = base4_reg;

endmodule

`default_nettype wire

// ----- src/psd_div_stage.sv -----
// ---------------------------------------------------------------------------
// psd_div_stage
// One bit of floor(dot*dot/lab): shift-add multiply with running reduction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psd_div_stage #(
    parameter int U_W = 34,
    parameter int BIT = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  psd_pkg::psd_ctl_t      ctl_in,
    input  wire logic [U_W-1:0]    dot_in,
    input  wire logic [U_W-1:0]    lab_in,
    input  wire logic [U_W-1:0]    base_in,
    input  wire logic [U_W-1:0]    q_in,
    input  wire logic [U_W-1:0]    r_in,
    output psd_pkg::psd_ctl_t      ctl_out,
    output logic [U_W-1:0]         dot_out,
    output logic [U_W-1:0]         lab_out,
    output logic [U_W-1:0]         base_out,
    output logic [U_W-1:0]         q_out,
    output logic [U_W-1:0]         r_out
);

    psd_pkg::psd_ctl_t  ctl_reg;
    logic [U_W-1:0]     dot_reg;
    logic [U_W-1:0]     lab_reg;
    logic [U_W-1:0]     base_reg;
    logic [U_W-1:0]     q_reg;
    logic [U_W-1:0]     r_reg;
    logic [U_W-1:0]     q_next;
    logic [U_W-1:0]     r_next;

    logic [U_W+1:0]     lab_x;
    logic [U_W+1:0]     r1;
    logic [U_W+1:0]     r2;
    logic [U_W+1:0]     r3;
    logic               c1;
    logic               c2;

    // r < lab and dot <= lab, so 2r + dot < 3*lab: two reductions suffice
    always_comb
    begin
        lab_x  = (U_W+2)'(lab_in);
        r1     = {1'b0, r_in, 1'b0} + (dot_in[BIT] ? (U_W+2)'(dot_in) : '0);
        c1     = (r1 >= lab_x);
        r2     = c1 ? (r1 - lab_x) : r1;
        c2     = (r2 >= lab_x);
        r3     = c2 ? (r2 - lab_x) : r2;
        r_next = r3[U_W-1:0];
        q_next = {q_in[U_W-2:0], 1'b0} + U_W'({c1 & c2, c1 ^ c2});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot_reg  <= dot_in;
            lab_reg  <= lab_in;
            base_reg <= base_in;
            q_reg    <= q_next;
            r_reg    <= r_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign dot_out  = dot_reg;
    assign lab_out  = lab_reg;
    assign base_out = base_reg;
    assign q_out    = q_reg;
    assign r_out    = r_reg;

endmodule

`default_nettype wire

// ----- src/point_segment_distance_top.sv -----
// ---------------------------------------------------------------------------
// point_segment_distance_top
// Squared distance of a 3D point to a segment, with capsule test.
// ---------------------------------------------------------------------------
//  channel  | signals                          | word
//  ---------+----------------------------------+-----------------------------
//  in       | in_valid / in_ready              | point_x, point_y, point_z
//  out      | out_valid / out_ready            | dist_sq, inside_res, region
//  cfg      | cfg_we, cfg_index, cfg_data      | one register per write
//
//  One word per cycle when the output does not stall.
//  The projection divider is bit-per-stage.
//  Reset clears valid bits and the configuration registers.
//  A stall at the output freezes the whole pipeline; in_ready follows it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_segment_distance_top #(
    parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [psd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_WIDTH-1:0]        cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [COORD_WIDTH-1:0]        point_x,
    input  wire logic [COORD_WIDTH-1:0]        point_y,
    input  wire logic [COORD_WIDTH-1:0]        point_z,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [psd_pkg::DIST_W-1:0]         dist_sq,
    output logic                               inside_res,
    output logic [1:0]                         region
);

    localparam int U_W   = 2 * COORD_WIDTH + 2;
    localparam int R_W   = 2 * COORD_WIDTH;
    localparam int CMP_W = (psd_pkg::DIST_W > R_W) ? psd_pkg::DIST_W : R_W;

    logic [COORD_WIDTH-1:0] start_x_reg, start_y_reg, start_z_reg;
    logic [COORD_WIDTH-1:0] end_x_reg, end_y_reg, end_z_reg;
    logic [COORD_WIDTH-1:0] radius_reg;
    logic [R_W-1:0]         rsq_reg;

    logic                   en;

    psd_pkg::psd_ctl_t      ctl_c  [U_W+1];
    logic [U_W-1:0]         dot_c  [U_W+1];
    logic [U_W-1:0]         lab_c  [U_W+1];
    logic [U_W-1:0]         base_c [U_W+1];
    logic [U_W-1:0]         q_c    [U_W+1];
    logic [U_W-1:0]         r_c    [U_W+1];

    psd_pkg::psd_ctl_t      fin_ctl_reg;
    logic [U_W-1:0]         fin_dist_reg;
    logic [U_W-1:0]         fin_dist_next;

    logic                   out_valid_reg;
    logic [psd_pkg::DIST_W-1:0] dist_sq_reg;
    logic                   inside_reg;
    logic [1:0]             region_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_z_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
            end_z_reg   <= '0;
            radius_reg  <= '0;
            rsq_reg     <= '0;
        end
        else
        begin
            rsq_reg <= R_W'(radius_reg) * R_W'(radius_reg);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    psd_pkg::REG_START_X: start_x_reg <= cfg_data;
                    psd_pkg::REG_START_Y: start_y_reg <= cfg_data;
                    psd_pkg::REG_START_Z: start_z_reg <= cfg_data;
                    psd_pkg::REG_END_X:   end_x_reg   <= cfg_data;
                    psd_pkg::REG_END_Y:   end_y_reg   <= cfg_data;
                    psd_pkg::REG_END_Z:   end_z_reg   <= cfg_data;
                    psd_pkg::REG_RADIUS:  radius_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    psd_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .start_x  (start_x_reg),
        .start_y  (start_y_reg),
        .start_z  (start_z_reg),
        .end_x    (end_x_reg),
        .end_y    (end_y_reg),
        .end_z    (end_z_reg),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z),
        .ctl      (ctl_c[0]),
        .dot      (dot_c[0]),
        .lab      (lab_c[0]),
        .base     (base_c[0])
    );

    assign q_c[0] = '0;
    assign r_c[0] = '0;

    for (genvar i = 0; i < U_W; i++)
    begin : g_div
        psd_div_stage #(
            .U_W (U_W),
            .BIT (U_W - 1 - i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_in   (ctl_c[i]),
            .dot_in   (dot_c[i]),
            .lab_in   (lab_c[i]),
            .base_in  (base_c[i]),
            .q_in     (q_c[i]),
            .r_in     (r_c[i]),
            .ctl_out  (ctl_c[i+1]),
            .dot_out  (dot_c[i+1]),
            .lab_out  (lab_c[i+1]),
            .base_out (base_c[i+1]),
            .q_out    (q_c[i+1]),
            .r_out    (r_c[i+1])
        );
    end

    always_comb
    begin
        if (ctl_c[U_W].region == psd_pkg::REGION_ON)
            fin_dist_next = (base_c[U_W] > q_c[U_W]) ? (base_c[U_W] - q_c[U_W]) : '0;
        else
            fin_dist_next = base_c[U_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_ctl_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_ctl_reg   <= ctl_c[U_W];
            out_valid_reg <= fin_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_dist_reg <= fin_dist_next;
            dist_sq_reg  <= psd_pkg::DIST_W'(fin_dist_reg);
            inside_reg   <= (CMP_W'(psd_pkg::DIST_W'(fin_dist_reg)) <= CMP_W'(rsq_reg));
            region_reg   <= fin_ctl_reg.region;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dist_sq    = dist_sq_reg;
    assign inside_res = inside_reg;
    assign region     = region_reg;

endmodule

`default_nettype wire

// ----- src/psd_checker.sv -----
// ---------------------------------------------------------------------------
// psd_checker
// Port-level checks of the point/segment block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "point_segment_distance_top_assert.svh"

module psd_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [psd_pkg::DIST_W-1:0]    dist_sq,
    input wire logic                          inside_res,
    input wire logic [1:0]                    region
);

    `PSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(dist_sq), "output word changed while stalled")
    `PSD_ASSERT_NOW(a_region_code, out_valid, region != 2'd3, "bad region code")
    `PSD_ASSERT_NOW(a_zero_inside, out_valid && (dist_sq == '0), inside_res, "zero distance not inside")
    `PSD_ASSERT_NOW(a_stall_ready, out_valid && !out_ready, !in_ready, "input taken during stall")

endmodule

bind point_segment_distance_top psd_checker u_psd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .dist_sq    (dist_sq),
    .inside_res (inside_res),
    .region     (region)
);

`default_nettype wire
